// ===== rtl/tdt_pkg.sv =====
// Package for the thread descriptor table: operation codes, status codes,
// slot states, flag bits and sizing defaults. No dependencies.
package tdt_pkg;

    localparam int TableDepthDefault = 128;
    localparam int ThreadsPerProcDefault = 64;

    localparam logic [3:0] OP_ADOPT = 4'd0;
    localparam logic [3:0] OP_CREATE = 4'd1;
    localparam logic [3:0] OP_EXIT = 4'd2;
    localparam logic [3:0] OP_JOIN_CLAIM = 4'd3;
    localparam logic [3:0] OP_JOIN_POLL = 4'd4;
    localparam logic [3:0] OP_DETACH = 4'd5;
    localparam logic [3:0] OP_REAP = 4'd6;
    localparam logic [3:0] OP_LIVE_COUNT = 4'd7;
    localparam logic [3:0] OP_USED_SLOTS = 4'd8;
    localparam logic [3:0] OP_STATS = 4'd9;

    localparam logic [2:0] STS_OK = 3'd0;
    localparam logic [2:0] STS_BAD_ARG = 3'd1;
    localparam logic [2:0] STS_FULL = 3'd2;
    localparam logic [2:0] STS_NO_THREAD = 3'd3;
    localparam logic [2:0] STS_INVALID = 3'd4;
    localparam logic [2:0] STS_DEADLOCK = 3'd5;
    localparam logic [2:0] STS_NOT_READY = 3'd6;

    localparam logic [1:0] SLOT_FREE = 2'd0;
    localparam logic [1:0] SLOT_LIVE = 2'd1;
    localparam logic [1:0] SLOT_EXITED = 2'd2;

    localparam int FL_DETACHED = 0;
    localparam int FL_JOINING = 1;
    localparam int FL_MAIN = 2;

    localparam logic CFG_STACK_MIN = 1'b0;
    localparam logic CFG_STACK_MAX = 1'b1;

    // One descriptor as it travels along the chain of cells.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] tid;
        logic [15:0] owner;
        logic [2:0]  flags;
        logic [63:0] ret;
        logic [63:0] base;
        logic [31:0] len;
    } t_desc;

endpackage

// ===== rtl/tdt_cell.sv =====
// One cell of the descriptor ring: holds a descriptor and passes it on.
// Depends on tdt_pkg.
module tdt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  tdt_pkg::t_desc i_desc,
    output tdt_pkg::t_desc o_desc
);
    import tdt_pkg::*;

    t_desc r_desc;

    // Only the state is reset; the rest of the payload is don't-care when free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc.status <= SLOT_FREE;
        end else if (i_shift) begin
            r_desc.status <= i_desc.status;
        end
        if (i_shift) begin
            r_desc.tid   <= i_desc.tid;
            r_desc.owner <= i_desc.owner;
            r_desc.flags <= i_desc.flags;
            r_desc.ret   <= i_desc.ret;
            r_desc.base  <= i_desc.base;
            r_desc.len   <= i_desc.len;
        end
    end

    assign o_desc = r_desc;

endmodule

// ===== rtl/thread_descriptor_table_unit.sv =====
// Top level of the thread descriptor table: a ring of descriptor cells that
// rotates past one edit point, plus the request sequencer. Depends on tdt_pkg
// and tdt_cell.
//
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_ready  | op, tids, pid, words, length
//  out     | output    | o_valid / i_ready  | status, tid, words, counts, wake
//  cfg     | input     | i_cfg_we           | i_cfg_index, i_cfg_data
//
// Each item takes two passes around the ring of TABLE_DEPTH cells (a scan
// pass, a decide state, then an edit pass), and o_valid is set from the done
// state that follows the edit pass. One item is in work at a time:
// o_ready falls on acceptance and rises once the result has been taken, so
// a new item is not taken before the last item's result is taken. The
// result register holds while i_ready is low. Reset is synchronous and clears
// all slots to free at once through the cells' state bits.
module thread_descriptor_table_unit #(
    parameter int TABLE_DEPTH = tdt_pkg::TableDepthDefault,
    parameter int THREADS_PER_PROCESS = tdt_pkg::ThreadsPerProcDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_op,
    input  logic [15:0] i_caller_tid,
    input  logic [15:0] i_owner_pid,
    input  logic [15:0] i_target_tid,
    input  logic [63:0] i_word_value,
    input  logic [31:0] i_stack_length,
    input  logic [63:0] i_stack_top_addr,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_tid_out,
    output logic [63:0] o_return_word,
    output logic [31:0] o_count_out,
    output logic [63:0] o_release_base,
    output logic [31:0] o_release_length,
    output logic        o_wake_joiners,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tdt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_EDIT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // What the edit pass does at its chosen position.
    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_ADOPT = 3'd1;
    localparam logic [2:0] E_CREATE = 3'd2;
    localparam logic [2:0] E_EXIT = 3'd3;
    localparam logic [2:0] E_JOIN = 3'd4;
    localparam logic [2:0] E_DETACH = 3'd5;
    localparam logic [2:0] E_POLL = 3'd6;
    localparam logic [2:0] E_REAP = 3'd7;

    t_desc w_ring [TABLE_DEPTH];
    t_desc w_head_in;
    logic  w_shift;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                tdt_cell u_cell (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(w_shift),
                                 .i_desc(w_head_in), .o_desc(w_ring[0]));
            end else begin : g_body
                tdt_cell u_cell (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(w_shift),
                                 .i_desc(w_ring[g-1]), .o_desc(w_ring[g]));
            end
        end
    endgenerate

    // The tail cell feeds back to the head; r_pos tracks which original slot
    // index currently sits in the tail, so lowest-index order is kept.
    t_desc w_tail;
    assign w_tail = w_ring[TABLE_DEPTH-1];

    logic [2:0]  r_state;
    logic [IW-1:0] r_pos;
    logic [31:0] r_min, r_max, r_created, r_reaped;
    logic [3:0]  r_op;
    logic [15:0] r_caller, r_pid, r_target;
    logic [63:0] r_word, r_top;
    logic [31:0] r_slen;

    // Scan results.
    logic          r_cl_hit, r_tg_hit, r_fr_hit;
    logic [IW-1:0] r_cl_idx, r_tg_idx, r_fr_idx;
    t_desc         r_tg_desc, r_cl_desc;
    logic [CW-1:0] r_n_owned, r_n_live, r_n_used;

    logic [2:0]    r_edit;
    logic [IW-1:0] r_edit_idx;
    logic [IW-1:0] r_edit_idx2;
    logic          r_adopt_too;
    logic [2:0]    r_sts;
    logic [63:0]   r_ret, r_rbase;
    logic [31:0]   r_rlen, r_cnt;
    logic [15:0]   r_tido;
    logic          r_wake;
    logic          r_ovalid;

    assign w_shift = (r_state == S_SCAN) || (r_state == S_EDIT);
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    // Edit at the head: applies the pending change as the slot rotates past.
    logic          w_at1, w_at2;
    logic [CW-1:0] w_reap_cnt;
    assign w_at1 = (r_pos == r_edit_idx);
    assign w_at2 = r_adopt_too && (r_pos == r_edit_idx2);

    always_comb begin
        w_head_in = w_tail;
        if (r_state == S_EDIT) begin
            if (w_at2) begin
                w_head_in.status = SLOT_LIVE;
                w_head_in.tid    = r_caller;
                w_head_in.owner  = r_pid;
                w_head_in.flags  = 3'b101;
                w_head_in.ret    = '0;
                w_head_in.base   = '0;
                w_head_in.len    = '0;
            end
            if (w_at1) begin
                case (r_edit)
                    E_ADOPT: begin
                        w_head_in.status = SLOT_LIVE;
                        w_head_in.tid    = r_caller;
                        w_head_in.owner  = r_pid;
                        w_head_in.flags  = 3'b101;
                        w_head_in.ret    = '0;
                        w_head_in.base   = '0;
                        w_head_in.len    = '0;
                    end
                    E_CREATE: begin
                        w_head_in.status = SLOT_LIVE;
                        w_head_in.tid    = r_target;
                        w_head_in.owner  = r_pid;
                        w_head_in.flags  = '0;
                        w_head_in.ret    = '0;
                        w_head_in.base   = r_word;
                        w_head_in.len    = r_slen;
                    end
                    E_EXIT: begin
                        // The flags may come from an adoption into this same slot.
                        w_head_in.ret  = r_word;
                        w_head_in.base = '0;
                        w_head_in.len  = '0;
                        w_head_in.status = w_head_in.flags[FL_DETACHED] ? SLOT_FREE
                                                                        : SLOT_EXITED;
                    end
                    E_JOIN: w_head_in.flags[FL_JOINING] = 1'b1;
                    E_DETACH: begin
                        w_head_in.flags[FL_DETACHED] = 1'b1;
                        if (w_tail.status == SLOT_EXITED) w_head_in.status = SLOT_FREE;
                    end
                    E_POLL: w_head_in.status = SLOT_FREE;
                    default: ;
                endcase
            end
            if (r_edit == E_REAP && w_tail.status != SLOT_FREE && w_tail.owner == r_pid)
                w_head_in.status = SLOT_FREE;
        end
    end

    assign w_reap_cnt = (r_edit == E_REAP && w_tail.status != SLOT_FREE
                         && w_tail.owner == r_pid) ? CW'(1) : '0;

    // Decision logic from the scan results.
    logic        w_cl_ok, w_top_bad, w_len_bad;
    logic [64:0] w_lim;
    assign w_lim = {1'b0, r_word} + {33'b0, r_slen};
    assign w_len_bad = (r_slen < r_min) || (r_slen > r_max);
    assign w_top_bad = (r_top <= r_word) || ({1'b0, r_top} > w_lim);
    // The caller can be adopted when found or a free slot exists.
    assign w_cl_ok = r_cl_hit || r_fr_hit;

    logic w_tg_own;
    assign w_tg_own = r_tg_hit && r_tg_desc.owner == r_pid;

    // Second free slot for create after adoption, found in the same scan.
    logic          r_fr2_hit;
    logic [IW-1:0] r_fr2_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= 32'd16384;
            r_max     <= 32'd8388608;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STACK_MIN: r_min <= i_cfg_data;
                CFG_STACK_MAX: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_created <= '0;
            r_reaped  <= '0;
            r_pos     <= '0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op     <= i_op;
                        r_caller <= i_caller_tid;
                        r_pid    <= i_owner_pid;
                        r_target <= i_target_tid;
                        r_word   <= i_word_value;
                        r_slen   <= i_stack_length;
                        r_top    <= i_stack_top_addr;
                        r_cl_hit <= 1'b0; r_tg_hit <= 1'b0; r_fr_hit <= 1'b0;
                        r_fr2_hit <= 1'b0;
                        r_n_owned <= '0; r_n_live <= '0; r_n_used <= '0;
                        r_edit   <= E_NONE;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Tail holds slot r_pos; the ring rotates once per pass.
                    if (w_tail.status != SLOT_FREE) begin
                        r_n_used <= r_n_used + CW'(1);
                        if (w_tail.owner == r_pid) begin
                            r_n_owned <= r_n_owned + CW'(1);
                            if (w_tail.status == SLOT_LIVE) r_n_live <= r_n_live + CW'(1);
                        end
                        if (!r_cl_hit && w_tail.tid == r_caller) begin
                            r_cl_hit <= 1'b1; r_cl_idx <= r_pos; r_cl_desc <= w_tail;
                        end
                        if (!r_tg_hit && w_tail.tid == r_target) begin
                            r_tg_hit <= 1'b1; r_tg_idx <= r_pos; r_tg_desc <= w_tail;
                        end
                    end else begin
                        if (!r_fr_hit) begin
                            r_fr_hit <= 1'b1; r_fr_idx <= r_pos;
                        end else if (!r_fr2_hit) begin
                            r_fr2_hit <= 1'b1; r_fr2_idx <= r_pos;
                        end
                    end
                    r_pos <= (r_pos == IW'(TABLE_DEPTH - 1)) ? '0 : r_pos + IW'(1);
                    if (r_pos == IW'(TABLE_DEPTH - 1)) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_sts <= STS_OK; r_tido <= '0; r_ret <= '0; r_cnt <= '0;
                    r_rbase <= '0; r_rlen <= '0; r_wake <= 1'b0;
                    r_edit <= E_NONE; r_adopt_too <= 1'b0;
                    r_edit_idx <= r_fr_idx; r_edit_idx2 <= r_fr_idx;
                    r_state <= S_EDIT;
                    case (r_op)
                        OP_ADOPT: begin
                            if (!w_cl_ok) r_sts <= STS_FULL;
                            else begin
                                r_tido <= r_caller;
                                if (!r_cl_hit) begin
                                    r_edit <= E_ADOPT;
                                    r_created <= r_created + 32'd1;
                                end
                            end
                        end
                        OP_CREATE: begin
                            if (!w_cl_ok || r_top == '0
                                || (r_word != '0 && (w_len_bad || w_top_bad))) begin
                                r_sts <= STS_BAD_ARG;
                                if (!r_cl_hit && w_cl_ok) begin
                                    r_edit <= E_ADOPT;
                                    r_created <= r_created + 32'd1;
                                end
                            end else begin
                                // Adoption adds an entry owned by this pid.
                                if ((32'(r_n_owned) + ((!r_cl_hit) ? 32'd1 : 32'd0))
                                    >= 32'(THREADS_PER_PROCESS)
                                    || (r_cl_hit ? !r_fr_hit : !r_fr2_hit)) begin
                                    r_sts <= STS_FULL;
                                    if (!r_cl_hit) begin
                                        r_edit <= E_ADOPT;
                                        r_created <= r_created + 32'd1;
                                    end
                                end else begin
                                    r_edit <= E_CREATE;
                                    r_tido <= r_target;
                                    r_created <= r_created + (r_cl_hit ? 32'd1 : 32'd2);
                                    if (!r_cl_hit) begin
                                        r_adopt_too <= 1'b1;
                                        r_edit_idx  <= r_fr2_idx;
                                    end
                                end
                            end
                        end
                        OP_EXIT: begin
                            if (!r_cl_hit) begin
                                // Newly adopted main thread is live and detached.
                                if (r_fr_hit) begin
                                    r_created <= r_created + 32'd1;
                                    r_adopt_too <= 1'b1;
                                    r_edit <= E_EXIT;
                                    r_reaped <= r_reaped + 32'd1;
                                end
                                r_cnt <= 32'(r_n_live);
                            end else if (r_cl_desc.status == SLOT_LIVE) begin
                                r_edit <= E_EXIT; r_edit_idx <= r_cl_idx;
                                if (r_cl_desc.base != '0 && r_cl_desc.len != '0) begin
                                    r_rbase <= r_cl_desc.base; r_rlen <= r_cl_desc.len;
                                end
                                if (r_cl_desc.flags[FL_DETACHED])
                                    r_reaped <= r_reaped + 32'd1;
                                else r_wake <= 1'b1;
                                r_cnt <= 32'(r_n_live)
                                       - ((r_cl_desc.owner == r_pid) ? 32'd1 : 32'd0);
                            end else r_cnt <= 32'(r_n_live);
                        end
                        OP_JOIN_CLAIM, OP_DETACH: begin
                            if (!w_cl_ok) r_sts <= STS_BAD_ARG;
                            else begin
                                if (!r_cl_hit) begin
                                    r_adopt_too <= 1'b1;
                                    r_created <= r_created + 32'd1;
                                end
                                if (r_op == OP_JOIN_CLAIM && r_target == r_caller)
                                    r_sts <= STS_DEADLOCK;
                                else if (!r_tg_hit && !r_cl_hit && r_target == r_caller)
                                    // Detach of self just adopted: detached already.
                                    r_sts <= STS_INVALID;
                                else if (!w_tg_own) r_sts <= STS_NO_THREAD;
                                else if (r_tg_desc.flags[FL_DETACHED]
                                         || r_tg_desc.flags[FL_JOINING])
                                    r_sts <= STS_INVALID;
                                else begin
                                    r_edit <= (r_op == OP_JOIN_CLAIM) ? E_JOIN : E_DETACH;
                                    r_edit_idx <= r_tg_idx;
                                    if (r_op == OP_DETACH && r_tg_desc.status == SLOT_EXITED)
                                        r_reaped <= r_reaped + 32'd1;
                                end
                            end
                        end
                        OP_JOIN_POLL: begin
                            if (!r_tg_hit) r_sts <= STS_NO_THREAD;
                            else if (r_tg_desc.status == SLOT_EXITED) begin
                                r_ret <= r_tg_desc.ret;
                                r_edit <= E_POLL; r_edit_idx <= r_tg_idx;
                                r_reaped <= r_reaped + 32'd1;
                            end else r_sts <= STS_NOT_READY;
                        end
                        OP_REAP: r_edit <= E_REAP;
                        OP_LIVE_COUNT: r_cnt <= 32'(r_n_live);
                        OP_USED_SLOTS: r_cnt <= 32'(r_n_used);
                        OP_STATS: r_cnt <= (r_target == '0) ? r_created : r_reaped;
                        default: r_sts <= STS_INVALID;
                    endcase
                end
                S_EDIT: begin
                    r_reaped <= r_reaped + 32'(w_reap_cnt);
                    r_pos <= (r_pos == IW'(TABLE_DEPTH - 1)) ? '0 : r_pos + IW'(1);
                    if (r_pos == IW'(TABLE_DEPTH - 1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // For exit without an entry, when a free slot exists, the caller is adopted
    // and exited in the same slot on the edit pass; being detached, that slot ends free.
    assign o_valid          = r_ovalid;
    assign o_status         = r_sts;
    assign o_tid_out        = r_tido;
    assign o_return_word    = r_ret;
    assign o_count_out      = r_cnt;
    assign o_release_base   = r_rbase;
    assign o_release_length = r_rlen;
    assign o_wake_joiners   = r_wake;

endmodule

// ===== rtl/tdt_checker.sv =====
// Port-level checks for the thread descriptor table.
// Depends on tdt_pkg; bound to thread_descriptor_table_unit.
module tdt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic        o_wake_joiners,
    input logic [15:0] o_tid_out,
    input logic [63:0] o_return_word
);
    import tdt_pkg::*;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while a result waits");

    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("second item taken while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped under stall");

    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wake_joiners |-> o_status == STS_OK)
        else $error("wake with failing status");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STS_OK |-> o_tid_out == '0 && o_return_word == '0)
        else $error("error result carries data");

endmodule

bind thread_descriptor_table_unit tdt_checker u_tdt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_wake_joiners(o_wake_joiners), .o_tid_out(o_tid_out),
    .o_return_word(o_return_word)
);
